// ===== sv/qsv_pkg.sv =====
// ----------------------------------------------------------------------------
// qsv_pkg
// Types, constants and fixed-point helpers of the three-qubit state vector
// simulator.
// ----------------------------------------------------------------------------
`default_nettype none

package qsv_pkg;

  localparam int QUBITS    = 3;
  localparam int NST       = 1 << QUBITS;
  localparam int IDXW      = QUBITS;
  localparam int PAIRW     = QUBITS - 1;
  localparam int QW        = 2;
  localparam int OPW       = 3;
  localparam int FRAC_BITS = 30;
  localparam int AMPW      = 64;
  localparam int PARTW     = 32;
  localparam int PW        = 31;
  localparam int ACCW      = 72;
  localparam int DVW       = 62;
  localparam int RTW       = 31;
  localparam int SQ_STEPS  = DVW / 2;
  localparam int SQCW      = $clog2(SQ_STEPS);
  localparam int DV_STEPS  = DVW;
  localparam int DVCW      = $clog2(DV_STEPS);
  localparam int STW       = 3;

  localparam logic [PW-1:0]   ONE_P   = PW'(1) << FRAC_BITS;
  localparam logic [AMPW-1:0] AMP_ONE = {PARTW'(1) << FRAC_BITS, PARTW'(0)};

  typedef enum logic [OPW-1:0] {
    OP_RESET = 3'd0,
    OP_GATE  = 3'd1,
    OP_CNOT  = 3'd2,
    OP_TOFF  = 3'd3,
    OP_MEAS  = 3'd4,
    OP_PROB  = 3'd5,
    OP_BLOCH = 3'd6,
    OP_NOP   = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_LOAD, S_GATE, S_FLIP, S_BLOCH, S_MSUM, S_PROB,
    S_WAIT, S_MWAIT, S_MDEC, S_SQRT, S_SCAN, S_DIV, S_FIN
  } state_t;

  typedef enum logic [2:0] {A_G00, A_G01, A_G10, A_G11, A_H0, A_H1} a_sel_t;
  typedef enum logic {B_H0, B_H1} b_sel_t;
  typedef enum logic [1:0] {D_RI, D_ZP, D_ZN} dst_t;
  typedef enum logic [2:0] {W_ACC, W_H0, W_H1, W_ZERO, W_DIV} wr_sel_t;
  typedef enum logic [1:0] {R_ZERO, R_PROB, R_BLOCH, R_MEAS} res_t;

  typedef struct packed {
    logic            req_load;
    logic            clr_all;
    logic            acc_clr;
    logic            ld_h0;
    logic            ld_h1;
    logic [IDXW-1:0] rd_idx;
    logic            wr_en;
    logic [IDXW-1:0] wr_idx;
    wr_sel_t         wr_sel;
    logic            mul_en;
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    logic            conj;
    logic            dbl;
    dst_t            dst;
    logic            meas_dec;
    logic            sqrt_start;
    logic            div_start;
    logic            div_im;
    logic            div_keep;
    logic            res_load;
    res_t            res_kind;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic outcome;
    logic sqrt_busy;
    logic div_busy;
  } stat_t;

  function automatic logic signed [ACCW-1:0] rnd(input logic signed [ACCW-1:0] a);
    logic signed [ACCW-1:0] s;
    s = a + (ACCW'(1) << (FRAC_BITS - 1));
    return s >>> FRAC_BITS;
  endfunction

  function automatic logic [PARTW-1:0] sat32(input logic signed [ACCW-1:0] v);
    logic [PARTW-1:0] r;
    if (v > $signed({{(ACCW-PARTW){1'b0}}, 32'h7fffffff})) r = 32'h7fffffff;
    else if (v < $signed({{(ACCW-PARTW){1'b1}}, 32'h80000000})) r = 32'h80000000;
    else r = v[PARTW-1:0];
    return r;
  endfunction

  function automatic logic [PW-1:0] satp(input logic signed [ACCW-1:0] v);
    logic [PW-1:0] r;
    if (v[ACCW-1]) r = '0;
    else if (v > $signed(ACCW'(ONE_P))) r = ONE_P;
    else r = v[PW-1:0];
    return r;
  endfunction

  function automatic logic [IDXW-1:0] weight(input logic [QW-1:0] q);
    return IDXW'(1) << (QUBITS - 1 - int'(q));
  endfunction

  // index of the pair member whose qubit-q bit is zero
  function automatic logic [IDXW-1:0] pidx(input logic [PAIRW-1:0] p,
                                           input logic [QW-1:0] q);
    logic [IDXW-1:0] r;
    int pos;
    pos = QUBITS - 1 - int'(q);
    for (int b = 0; b < IDXW; b++) begin
      if (b < pos) r[b] = p[b];
      else if (b == pos) r[b] = 1'b0;
      else r[b] = p[b-1];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qsv_sqrt.sv =====
// ----------------------------------------------------------------------------
// qsv_sqrt
// Digit-recurrence integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qsv_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [qsv_pkg::DVW-1:0] radicand,
  output logic                       busy,
  output logic [qsv_pkg::RTW-1:0]    root
);
  import qsv_pkg::*;

  logic [DVW-1:0]  v_r;
  logic [33:0]     rem_r;
  logic [RTW-1:0]  root_r;
  logic [SQCW-1:0] cnt_r;
  logic            busy_r;
  logic [35:0]     rem_s;
  logic [35:0]     trial;

  assign rem_s = {rem_r, v_r[DVW-1 -: 2]};
  assign trial = {3'b000, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= SQCW'(SQ_STEPS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r <= v_r << 2;
      if (rem_s >= trial) begin
        rem_r  <= 34'(rem_s - trial);
        root_r <= {root_r[RTW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_s[33:0];
        root_r <= {root_r[RTW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== sv/qsv_div.sv =====
// ----------------------------------------------------------------------------
// qsv_div
// Restoring divider for renormalization: round(x * 2^FRAC / norm), half away
// from zero, saturated to 32-bit signed. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qsv_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [qsv_pkg::PARTW-1:0] x,
  input  wire logic [qsv_pkg::RTW-1:0]     norm,
  output logic                             busy,
  output logic [qsv_pkg::PARTW-1:0]        q
);
  import qsv_pkg::*;

  logic [DVW-1:0]   dq_r;
  logic [RTW-1:0]   rem_r;
  logic [RTW-1:0]   d_r;
  logic             neg_r;
  logic [DVCW-1:0]  cnt_r;
  logic             busy_r;
  logic [PARTW-1:0] ax;
  logic [DVW-1:0]   dividend;
  logic [RTW:0]     t;

  assign ax       = x[PARTW-1] ? PARTW'(-x) : PARTW'(x);
  assign dividend = (DVW'(ax) << FRAC_BITS) + DVW'(norm >> 1);
  assign t        = {rem_r, dq_r[DVW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DVCW'(DV_STEPS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      d_r   <= norm;
      neg_r <= x[PARTW-1];
    end else if (busy_r) begin
      if (t >= {1'b0, d_r}) begin
        rem_r <= RTW'(t - {1'b0, d_r});
        dq_r  <= {dq_r[DVW-2:0], 1'b1};
      end else begin
        rem_r <= t[RTW-1:0];
        dq_r  <= {dq_r[DVW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      if (dq_r > DVW'(33'h080000000)) q = 32'h80000000;
      else q = PARTW'(-dq_r[PARTW-1:0]);
    end else begin
      if (dq_r > DVW'(32'h7fffffff)) q = 32'h7fffffff;
      else q = dq_r[PARTW-1:0];
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== sv/qsv_dp.sv =====
// ----------------------------------------------------------------------------
// qsv_dp
// Datapath: amplitude registers, complex multiply-accumulate unit, measurement
// decision, square root and divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsv_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [31:0]               random_draw,
  input  wire logic [qsv_pkg::AMPW-1:0]  gate_00,
  input  wire logic [qsv_pkg::AMPW-1:0]  gate_01,
  input  wire logic [qsv_pkg::AMPW-1:0]  gate_10,
  input  wire logic [qsv_pkg::AMPW-1:0]  gate_11,
  input  wire qsv_pkg::cmd_t             cmd,
  output qsv_pkg::stat_t                 stat,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           measured_bit,
  output logic [qsv_pkg::PW-1:0]         probability,
  output logic [qsv_pkg::PARTW-1:0]      bloch_x,
  output logic [qsv_pkg::PARTW-1:0]      bloch_y,
  output logic [qsv_pkg::PARTW-1:0]      bloch_z
);
  import qsv_pkg::*;

  logic [AMPW-1:0]  amp_r [NST];
  logic [AMPW-1:0]  h0_r, h1_r;
  logic [AMPW-1:0]  g_r [4];
  logic [31:0]      draw_r;
  logic [AMPW-1:0]  a_op, b_op, wdata;

  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic               pv_r, pconj_r, pdbl_r;
  dst_t               pdst_r;
  logic signed [ACCW-1:0] acc_re_r, acc_im_r, acc_z_r;
  logic signed [ACCW-1:0] e0, e1, e2, e3, sre, sim;

  logic [PW-1:0]    p1v, p0v;
  logic             bit_nxt;
  logic             outc_r;
  logic [PW-1:0]    pc_r;
  logic             sq_busy, dv_busy;
  logic [RTW-1:0]   root, norm;
  logic [PARTW-1:0] dq, dre_r;

  logic             out_valid_r, mb_r;
  logic [PW-1:0]    prob_r;
  logic [PARTW-1:0] bx_r, by_r, bz_r;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      g_r[0] <= gate_00;
      g_r[1] <= gate_01;
      g_r[2] <= gate_10;
      g_r[3] <= gate_11;
      draw_r <= random_draw;
    end
    if (cmd.ld_h0) h0_r <= amp_r[cmd.rd_idx];
    if (cmd.ld_h1) h1_r <= amp_r[cmd.rd_idx];
    if (cmd.div_keep) dre_r <= dq;
  end

  always_comb begin
    unique case (cmd.wr_sel)
      W_ACC:   wdata = {sat32(rnd(acc_re_r)), sat32(rnd(acc_im_r))};
      W_H0:    wdata = h0_r;
      W_H1:    wdata = h1_r;
      W_DIV:   wdata = {dre_r, dq};
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) begin
      for (int k = 0; k < NST; k++) amp_r[k] <= (k == 0) ? AMP_ONE : '0;
    end else if (cmd.wr_en) begin
      amp_r[cmd.wr_idx] <= wdata;
    end
  end

  always_comb begin
    unique case (cmd.a_sel)
      A_G00:   a_op = g_r[0];
      A_G01:   a_op = g_r[1];
      A_G10:   a_op = g_r[2];
      A_G11:   a_op = g_r[3];
      A_H0:    a_op = h0_r;
      default: a_op = h1_r;
    endcase
    b_op = (cmd.b_sel == B_H0) ? h0_r : h1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else pv_r <= cmd.mul_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p0_r    <= $signed(a_op[63:32]) * $signed(b_op[63:32]);
      p1_r    <= $signed(a_op[31:0])  * $signed(b_op[31:0]);
      p2_r    <= $signed(a_op[63:32]) * $signed(b_op[31:0]);
      p3_r    <= $signed(a_op[31:0])  * $signed(b_op[63:32]);
      pconj_r <= cmd.conj;
      pdbl_r  <= cmd.dbl;
      pdst_r  <= cmd.dst;
    end
  end

  always_comb begin
    e0  = ACCW'(p0_r);
    e1  = ACCW'(p1_r);
    e2  = ACCW'(p2_r);
    e3  = ACCW'(p3_r);
    sre = pconj_r ? e0 + e1 : e0 - e1;
    sim = pconj_r ? e2 - e3 : e2 + e3;
    if (pdbl_r) begin
      sre = sre <<< 1;
      sim = sim <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      acc_z_r  <= '0;
    end else if (pv_r) begin
      unique case (pdst_r)
        D_RI: begin
          acc_re_r <= acc_re_r + sre;
          acc_im_r <= acc_im_r + sim;
        end
        D_ZP:    acc_z_r <= acc_z_r + sre;
        default: acc_z_r <= acc_z_r - sre;
      endcase
    end
  end

  // measurement decision
  assign p1v     = satp(rnd(acc_z_r));
  assign p0v     = ONE_P - p1v;
  assign bit_nxt = !(64'(draw_r) < (64'(p0v) << (32 - FRAC_BITS)));

  always_ff @(posedge clk) begin
    if (!rst_n) outc_r <= 1'b0;
    else if (cmd.meas_dec) outc_r <= bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.meas_dec) pc_r <= bit_nxt ? p1v : p0v;
  end

  qsv_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (DVW'(pc_r) << FRAC_BITS),
    .busy     (sq_busy),
    .root     (root)
  );

  assign norm = (root == '0) ? RTW'(ONE_P) : root;

  qsv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .x     (cmd.div_im ? $signed(h0_r[31:0]) : $signed(h0_r[63:32])),
    .norm  (norm),
    .busy  (dv_busy),
    .q     (dq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.res_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      mb_r   <= 1'b0;
      prob_r <= '0;
      bx_r   <= '0;
      by_r   <= '0;
      bz_r   <= '0;
      unique case (cmd.res_kind)
        R_PROB: prob_r <= satp(rnd(acc_z_r));
        R_BLOCH: begin
          bx_r <= sat32(rnd(acc_re_r));
          by_r <= sat32(rnd(acc_im_r));
          bz_r <= sat32(rnd(acc_z_r));
        end
        R_MEAS:  mb_r <= outc_r;
        default: mb_r <= 1'b0;
      endcase
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.outcome   = outc_r;
  assign stat.sqrt_busy = sq_busy;
  assign stat.div_busy  = dv_busy;

  assign out_valid    = out_valid_r;
  assign measured_bit = mb_r;
  assign probability  = prob_r;
  assign bloch_x      = bx_r;
  assign bloch_y      = by_r;
  assign bloch_z      = bz_r;

endmodule

`default_nettype wire

// ===== sv/qsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsv_ctrl
// Sequencer: walks amplitude pairs or indexes and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module qsv_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [qsv_pkg::OPW-1:0]    opcode,
  input  wire logic [qsv_pkg::QW-1:0]     qubit_a,
  input  wire logic [qsv_pkg::QW-1:0]     qubit_b,
  input  wire logic [qsv_pkg::QW-1:0]     qubit_c,
  input  wire logic [qsv_pkg::IDXW-1:0]   prob_index,
  input  wire qsv_pkg::stat_t             stat,
  output qsv_pkg::cmd_t                   cmd
);
  import qsv_pkg::*;

  state_t           state_r, state_nxt;
  logic [STW-1:0]   st_r, st_nxt;
  logic [PAIRW-1:0] pr_r, pr_nxt;
  logic [IDXW-1:0]  ix_r, ix_nxt;
  op_t              op_r, op_nxt;
  logic [QW-1:0]    qa_r, qa_nxt, qb_r, qb_nxt, qc_r, qc_nxt;
  logic [IDXW-1:0]  pi_r, pi_nxt;
  logic             mph_r, mph_nxt;
  res_t             kind_r, kind_nxt;

  logic [IDXW-1:0]  w, wc1, wc2, i_lo, i_hi, addr0;
  logic             va, vb, vc, flip, keep, last_pr, last_ix;

  assign va = int'(qubit_a) < QUBITS;
  assign vb = int'(qubit_b) < QUBITS;
  assign vc = int'(qubit_c) < QUBITS;

  assign w       = weight(qa_r);
  assign wc1     = weight(qb_r);
  assign wc2     = (op_r == OP_TOFF) ? weight(qc_r) : wc1;
  assign i_lo    = pidx(pr_r, qa_r);
  assign i_hi    = i_lo | w;
  assign flip    = (|(i_lo & wc1)) && (|(i_lo & wc2));
  assign keep    = (|(ix_r & w)) == stat.outcome;
  assign last_pr = pr_r == {PAIRW{1'b1}};
  assign last_ix = ix_r == {IDXW{1'b1}};
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    if (op_r == OP_PROB) addr0 = pi_r;
    else if (op_r == OP_MEAS) addr0 = mph_r ? ix_r : i_hi;
    else addr0 = i_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= '0;
      pr_r    <= '0;
      ix_r    <= '0;
      op_r    <= OP_NOP;
      qa_r    <= '0;
      qb_r    <= '0;
      qc_r    <= '0;
      pi_r    <= '0;
      mph_r   <= 1'b0;
      kind_r  <= R_ZERO;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      pr_r    <= pr_nxt;
      ix_r    <= ix_nxt;
      op_r    <= op_nxt;
      qa_r    <= qa_nxt;
      qb_r    <= qb_nxt;
      qc_r    <= qc_nxt;
      pi_r    <= pi_nxt;
      mph_r   <= mph_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    pr_nxt    = pr_r;
    ix_nxt    = ix_r;
    op_nxt    = op_r;
    qa_nxt    = qa_r;
    qb_nxt    = qb_r;
    qc_nxt    = qc_r;
    pi_nxt    = pi_r;
    mph_nxt   = mph_r;
    kind_nxt  = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = op_t'(opcode);
          qa_nxt   = qubit_a;
          qb_nxt   = qubit_b;
          qc_nxt   = qubit_c;
          pi_nxt   = prob_index;
          st_nxt   = '0;
          pr_nxt   = '0;
          mph_nxt  = 1'b0;
          kind_nxt = R_ZERO;
          state_nxt = S_FIN;
          unique case (op_t'(opcode))
            OP_RESET: state_nxt = S_CLR;
            OP_GATE:  if (va) state_nxt = S_LOAD;
            OP_CNOT:  if (va && vb && qubit_a != qubit_b) state_nxt = S_LOAD;
            OP_TOFF: begin
              if (va && vb && vc && qubit_a != qubit_b && qubit_a != qubit_c)
                state_nxt = S_LOAD;
            end
            OP_MEAS: begin
              if (va) begin
                state_nxt = S_LOAD;
                kind_nxt  = R_MEAS;
              end
            end
            OP_PROB: begin
              state_nxt = S_LOAD;
              kind_nxt  = R_PROB;
            end
            OP_BLOCH: begin
              if (va) begin
                state_nxt = S_LOAD;
                kind_nxt  = R_BLOCH;
              end
            end
            OP_NOP: state_nxt = S_FIN;
          endcase
        end
      end
      S_CLR: state_nxt = S_FIN;
      S_LOAD: begin
        if (st_r == '0) begin
          st_nxt = STW'(1);
        end else begin
          st_nxt = '0;
          unique case (op_r)
            OP_GATE:          state_nxt = S_GATE;
            OP_CNOT, OP_TOFF: state_nxt = S_FLIP;
            OP_BLOCH:         state_nxt = S_BLOCH;
            OP_MEAS:          state_nxt = mph_r ? S_DIV : S_MSUM;
            OP_PROB:          state_nxt = S_PROB;
            default:          state_nxt = S_FIN;
          endcase
        end
      end
      S_GATE: begin
        if (st_r == STW'(7)) begin
          st_nxt = '0;
          if (last_pr) state_nxt = S_FIN;
          else begin
            pr_nxt    = pr_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end else begin
          st_nxt = st_r + 1'b1;
        end
      end
      S_FLIP: begin
        if (st_r == STW'(1)) begin
          st_nxt = '0;
          if (last_pr) state_nxt = S_FIN;
          else begin
            pr_nxt    = pr_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end else begin
          st_nxt = st_r + 1'b1;
        end
      end
      S_BLOCH: begin
        if (st_r == STW'(2)) begin
          st_nxt = '0;
          if (last_pr) state_nxt = S_WAIT;
          else begin
            pr_nxt    = pr_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end else begin
          st_nxt = st_r + 1'b1;
        end
      end
      S_MSUM: begin
        if (last_pr) state_nxt = S_MWAIT;
        else begin
          pr_nxt    = pr_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_PROB:  state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_FIN;
      S_MWAIT: state_nxt = S_MDEC;
      S_MDEC: begin
        st_nxt    = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (st_r == '0) st_nxt = STW'(1);
        else if (!stat.sqrt_busy) begin
          st_nxt    = '0;
          ix_nxt    = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (keep) begin
          mph_nxt   = 1'b1;
          st_nxt    = '0;
          state_nxt = S_LOAD;
        end else if (last_ix) begin
          state_nxt = S_FIN;
        end else begin
          ix_nxt = ix_r + 1'b1;
        end
      end
      S_DIV: begin
        priority case (st_r)
          STW'(0): st_nxt = STW'(1);
          STW'(1): if (!stat.div_busy) st_nxt = STW'(2);
          STW'(2): st_nxt = STW'(3);
          default: begin
            if (!stat.div_busy) begin
              st_nxt = '0;
              if (last_ix) state_nxt = S_FIN;
              else begin
                ix_nxt    = ix_r + 1'b1;
                state_nxt = S_SCAN;
              end
            end
          end
        endcase
      end
      S_FIN: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.a_sel    = A_H0;
    cmd.b_sel    = B_H0;
    cmd.dst      = D_RI;
    cmd.wr_sel   = W_ZERO;
    cmd.res_kind = kind_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.req_load = in_valid;
        cmd.acc_clr  = in_valid;
      end
      S_CLR: cmd.clr_all = 1'b1;
      S_LOAD: begin
        cmd.rd_idx = (st_r == '0) ? addr0 : i_hi;
        cmd.ld_h0  = st_r == '0;
        cmd.ld_h1  = st_r != '0;
      end
      S_GATE: begin
        priority case (st_r)
          STW'(0): begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_G00;
          end
          STW'(1): begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_G01;
            cmd.b_sel  = B_H1;
          end
          STW'(3): begin
            cmd.wr_en   = 1'b1;
            cmd.wr_idx  = i_lo;
            cmd.wr_sel  = W_ACC;
            cmd.acc_clr = 1'b1;
          end
          STW'(4): begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_G10;
          end
          STW'(5): begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_G11;
            cmd.b_sel  = B_H1;
          end
          STW'(7): begin
            cmd.wr_en   = 1'b1;
            cmd.wr_idx  = i_hi;
            cmd.wr_sel  = W_ACC;
            cmd.acc_clr = 1'b1;
          end
          default: cmd.mul_en = 1'b0;
        endcase
      end
      S_FLIP: begin
        cmd.wr_en = 1'b1;
        if (st_r == '0) begin
          cmd.wr_idx = i_lo;
          cmd.wr_sel = flip ? W_H1 : W_H0;
        end else begin
          cmd.wr_idx = i_hi;
          cmd.wr_sel = flip ? W_H0 : W_H1;
        end
      end
      S_BLOCH: begin
        cmd.mul_en = 1'b1;
        cmd.conj   = 1'b1;
        priority case (st_r)
          STW'(0): begin
            cmd.b_sel = B_H1;
            cmd.dbl   = 1'b1;
          end
          STW'(1): cmd.dst = D_ZP;
          default: begin
            cmd.a_sel = A_H1;
            cmd.b_sel = B_H1;
            cmd.dst   = D_ZN;
          end
        endcase
      end
      S_MSUM, S_PROB: begin
        cmd.mul_en = 1'b1;
        cmd.conj   = 1'b1;
        cmd.dst    = D_ZP;
      end
      S_MDEC: cmd.meas_dec = 1'b1;
      S_SQRT: cmd.sqrt_start = st_r == '0;
      S_SCAN: begin
        cmd.wr_en  = !keep;
        cmd.wr_idx = ix_r;
      end
      S_DIV: begin
        cmd.wr_idx = ix_r;
        cmd.wr_sel = W_DIV;
        priority case (st_r)
          STW'(0): cmd.div_start = 1'b1;
          STW'(1): cmd.div_keep = !stat.div_busy;
          STW'(2): begin
            cmd.div_start = 1'b1;
            cmd.div_im    = 1'b1;
          end
          default: begin
            cmd.div_im = 1'b1;
            cmd.wr_en  = !stat.div_busy;
          end
        endcase
      end
      S_FIN: cmd.res_load = stat.out_free;
      default: cmd.res_load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/three_qubit_state_vector_sim.sv =====
// ----------------------------------------------------------------------------
// three_qubit_state_vector_sim
// Fixed-point state vector simulator for three qubits, one request at a time.
// ----------------------------------------------------------------------------
// Each request produces exactly one result. The block takes one request at a
// time; the result sits in an output register, so the next request is taken
// while it waits. Latency is set by the sequencer walking four amplitude
// pairs through one shared complex multiply-accumulate unit (four 32x32
// multipliers, one registered stage). Measurement is dominated by a
// one-bit-per-cycle square root and divider (two parts per kept
// amplitude).
// ----------------------------------------------------------------------------
`default_nettype none

module three_qubit_state_vector_sim (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode[2:0], qubit_a[4:3], qubit_b[6:5], qubit_c[8:7], prob_index[11:9],
  // random_draw[43:12], gate_00[107:44], gate_01[171:108], gate_10[235:172],
  // gate_11[299:236], zero pad[303:300]
  input  wire logic [303:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // measured_bit[0], probability[31:1], bloch_x[63:32], bloch_y[95:64],
  // bloch_z[127:96]
  output logic [127:0]      out_tdata
);
  import qsv_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic             mb;
  logic [PW-1:0]    prob;
  logic [PARTW-1:0] bx, by, bz;

  qsv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .opcode     (in_tdata[2:0]),
    .qubit_a    (in_tdata[4:3]),
    .qubit_b    (in_tdata[6:5]),
    .qubit_c    (in_tdata[8:7]),
    .prob_index (in_tdata[11:9]),
    .stat       (stat),
    .cmd        (cmd)
  );

  qsv_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .random_draw  (in_tdata[43:12]),
    .gate_00      (in_tdata[107:44]),
    .gate_01      (in_tdata[171:108]),
    .gate_10      (in_tdata[235:172]),
    .gate_11      (in_tdata[299:236]),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .measured_bit (mb),
    .probability  (prob),
    .bloch_x      (bx),
    .bloch_y      (by),
    .bloch_z      (bz)
  );

  assign out_tdata = {bz, by, bx, prob, mb};

endmodule

`default_nettype wire

// ===== verif/tb_three_qubit_state_vector_sim.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_qubit_state_vector_sim
// Self-checking testbench of the three-qubit state vector simulator. A local
// fixed-point model tracks the eight amplitudes and predicts every result.
// Directed tests cover reset, single-qubit gates, entanglers, measurement
// and the ignored cases. A random test follows: all opcodes mixed, with gate
// matrices mostly unitary with random content, plus raw random words.
// Requests come in bursts, and the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_three_qubit_state_vector_sim;
  import qsv_pkg::*;

  typedef logic signed [79:0] wide_t;

  typedef struct {
    op_t         op;
    logic [1:0]  qa, qb, qc;
    logic [2:0]  pidx;
    logic [31:0] draw;
    logic [63:0] g [4];
  } qreq_t;

  typedef struct {
    logic        mbit;
    logic [30:0] prob;
    logic [31:0] bx, by, bz;
  } qres_t;

  localparam logic [31:0] ONE_Q = 32'h4000_0000;
  localparam logic [31:0] HALF_RT2 = 32'h2D41_3CCD;
  localparam logic [63:0] C_ONE = {ONE_Q, 32'h0};
  localparam logic [63:0] C_ZERO = 64'h0;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [303:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  logic [63:0] amp_model [8];
  qres_t       pending_results [$];
  int          errors = 0;
  int          op_count [8];
  int          ones_measured = 0;
  int          results_seen = 0;
  int          cycle = 0;

  three_qubit_state_vector_sim dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // ---------------- fixed-point model ----------------
  function automatic wide_t mul(input logic [31:0] a, input logic [31:0] b);
    return wide_t'($signed(a)) * wide_t'($signed(b));
  endfunction

  function automatic logic [31:0] rsat(input wide_t v);
    wide_t r;
    r = (v + (wide_t'(1) <<< 29)) >>> 30;
    if (r > wide_t'(32'sh7fff_ffff)) return 32'h7fff_ffff;
    if (r < -wide_t'(64'sh8000_0000)) return 32'h8000_0000;
    return r[31:0];
  endfunction

  function automatic logic [30:0] rprob(input wide_t v);
    wide_t r;
    r = (v + (wide_t'(1) <<< 29)) >>> 30;
    if (r < 0) return '0;
    if (r > wide_t'(ONE_Q)) return ONE_Q[30:0];
    return r[30:0];
  endfunction

  function automatic wide_t cm_re(input logic [63:0] x, input logic [63:0] y);
    return mul(x[63:32], y[63:32]) - mul(x[31:0], y[31:0]);
  endfunction

  function automatic wide_t cm_im(input logic [63:0] x, input logic [63:0] y);
    return mul(x[63:32], y[31:0]) + mul(x[31:0], y[63:32]);
  endfunction

  function automatic wide_t mag2(input logic [63:0] x);
    return mul(x[63:32], x[63:32]) + mul(x[31:0], x[31:0]);
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] div_norm(input logic [31:0] x, input logic [63:0] norm);
    logic signed [63:0] n;
    logic [63:0] mag, q;
    n = 64'($signed(x)) <<< 30;
    mag = n < 0 ? 64'(-n) : 64'(n);
    q = (mag + norm / 2) / norm;
    if (n < 0) return q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
    return q > 64'h7fff_ffff ? 32'h7fff_ffff : q[31:0];
  endfunction

  function automatic void flip_model(input logic [2:0] c1, input logic [2:0] c2,
                                     input logic [2:0] t);
    logic [63:0] nw [8];
    for (int i = 0; i < 8; i++)
      nw[i] = (((i & c1) != 0) && ((i & c2) != 0)) ? amp_model[i ^ t] : amp_model[i];
    for (int i = 0; i < 8; i++) amp_model[i] = nw[i];
  endfunction

  function automatic qres_t predict_op(input qreq_t r);
    qres_t       o;
    logic [2:0]  w, wb, wc;
    logic        va, vb, vc, bit1;
    logic [63:0] a0, a1, norm;
    logic [31:0] p0, p1, pc;
    wide_t       acc_x, acc_y, acc_z, acc_p;
    o = '{mbit: 1'b0, prob: '0, bx: '0, by: '0, bz: '0};
    va = r.qa < 3;
    vb = r.qb < 3;
    vc = r.qc < 3;
    w  = 3'(4 >> r.qa);
    wb = 3'(4 >> r.qb);
    wc = 3'(4 >> r.qc);
    case (r.op)
      OP_RESET: begin
        for (int i = 0; i < 8; i++) amp_model[i] = C_ZERO;
        amp_model[0] = C_ONE;
      end
      OP_GATE: if (va) begin
        for (int i = 0; i < 8; i++) if ((i & w) == 0) begin
          a0 = amp_model[i];
          a1 = amp_model[i | w];
          amp_model[i] = {rsat(cm_re(r.g[0], a0) + cm_re(r.g[1], a1)),
                          rsat(cm_im(r.g[0], a0) + cm_im(r.g[1], a1))};
          amp_model[i | w] = {rsat(cm_re(r.g[2], a0) + cm_re(r.g[3], a1)),
                              rsat(cm_im(r.g[2], a0) + cm_im(r.g[3], a1))};
        end
      end
      OP_CNOT: if (va && vb && r.qa != r.qb) flip_model(wb, wb, w);
      OP_TOFF: if (va && vb && vc && r.qa != r.qb && r.qa != r.qc) flip_model(wb, wc, w);
      OP_MEAS: if (va) begin
        acc_p = 0;
        for (int i = 0; i < 8; i++) if ((i & w) != 0) acc_p += mag2(amp_model[i]);
        p1 = 32'(rprob(acc_p));
        p0 = ONE_Q - p1;
        bit1 = !(64'(r.draw) < (64'(p0) << 2));
        pc = bit1 ? p1 : p0;
        norm = isqrt(64'(pc) << 30);
        if (norm == 0) norm = 64'(ONE_Q);
        for (int i = 0; i < 8; i++) begin
          if (((i & w) != 0) != bit1) amp_model[i] = C_ZERO;
          else amp_model[i] = {div_norm(amp_model[i][63:32], norm),
                               div_norm(amp_model[i][31:0], norm)};
        end
        o.mbit = bit1;
      end
      OP_PROB: o.prob = rprob(mag2(amp_model[r.pidx]));
      OP_BLOCH: if (va) begin
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        for (int i = 0; i < 8; i++) if ((i & w) == 0) begin
          a0 = amp_model[i];
          a1 = amp_model[i | w];
          acc_x += 2 * (mul(a0[63:32], a1[63:32]) + mul(a0[31:0], a1[31:0]));
          acc_y += 2 * (mul(a0[63:32], a1[31:0]) - mul(a0[31:0], a1[63:32]));
          acc_z += mag2(a0) - mag2(a1);
        end
        o.bx = rsat(acc_x);
        o.by = rsat(acc_y);
        o.bz = rsat(acc_z);
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------- request side ----------------
  task automatic send_req(input qreq_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, r.g[3], r.g[2], r.g[1], r.g[0], r.draw, r.pidx, r.qc, r.qb,
                  r.qa, r.op};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_op(r));
    op_count[r.op]++;
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_op(input op_t op, input logic [1:0] qa, input logic [1:0] qb,
                         input logic [1:0] qc, input logic [2:0] pidx,
                         input logic [31:0] draw);
    qreq_t r;
    r.op = op;
    r.qa = qa;
    r.qb = qb;
    r.qc = qc;
    r.pidx = pidx;
    r.draw = draw;
    r.g = '{C_ONE, C_ZERO, C_ZERO, C_ONE};
    send_req(r);
    idle($urandom_range(0, 3));
  endtask

  task automatic send_gate(input logic [1:0] qa, input logic [63:0] g00,
                           input logic [63:0] g01, input logic [63:0] g10,
                           input logic [63:0] g11);
    qreq_t r;
    r.op = OP_GATE;
    r.qa = qa;
    r.qb = 2'($urandom);
    r.qc = 2'($urandom);
    r.pidx = 3'($urandom);
    r.draw = $urandom;
    r.g = '{g00, g01, g10, g11};
    send_req(r);
    idle($urandom_range(0, 3));
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    cycle <= cycle + 1;
    case ((cycle / 300) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= cycle[3];
    endcase
  end

  task automatic report(input string field, input logic [31:0] got,
                        input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    qres_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding", $realtime);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[0] != e.mbit) report("measured_bit", 32'(out_tdata[0]), 32'(e.mbit));
        if (out_tdata[31:1] != e.prob) report("probability", 32'(out_tdata[31:1]), 32'(e.prob));
        if (out_tdata[63:32] != e.bx) report("bloch_x", out_tdata[63:32], e.bx);
        if (out_tdata[95:64] != e.by) report("bloch_y", out_tdata[95:64], e.by);
        if (out_tdata[127:96] != e.bz) report("bloch_z", out_tdata[127:96], e.bz);
        if (e.mbit) ones_measured++;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_probe();
    send_op(OP_RESET, 0, 0, 0, 0, 0);
    send_op(OP_PROB, 0, 0, 0, 3'd0, 0);
    send_op(OP_PROB, 0, 0, 0, 3'd7, 0);
    send_op(OP_BLOCH, 0, 0, 0, 0, 0);
  endtask

  task automatic test_single_gates();
    send_gate(0, {HALF_RT2, 32'h0}, {HALF_RT2, 32'h0}, {HALF_RT2, 32'h0},
              {-HALF_RT2, 32'h0});
    send_gate(1, C_ZERO, C_ONE, C_ONE, C_ZERO);
    send_gate(2, C_ZERO, {32'h0, -ONE_Q}, {32'h0, ONE_Q}, C_ZERO);
    send_gate(0, C_ONE, C_ZERO, C_ZERO, {HALF_RT2, HALF_RT2});
    send_op(OP_BLOCH, 0, 0, 0, 0, 0);
    send_op(OP_BLOCH, 1, 0, 0, 0, 0);
    send_op(OP_BLOCH, 2, 0, 0, 0, 0);
    send_op(OP_BLOCH, 3, 0, 0, 0, 0);
    send_gate(3, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    send_gate(1, {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
              {2{32'h8000_0000}});
    send_gate(2, {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}},
              {2{32'h7fff_ffff}});
    send_op(OP_PROB, 0, 0, 0, 3'd5, 0);
    send_op(OP_BLOCH, 1, 0, 0, 0, 0);
  endtask

  task automatic test_entanglers();
    send_op(OP_RESET, 0, 0, 0, 0, 0);
    send_gate(0, {HALF_RT2, 32'h0}, {HALF_RT2, 32'h0}, {HALF_RT2, 32'h0},
              {-HALF_RT2, 32'h0});
    send_op(OP_CNOT, 1, 0, 0, 0, 0);
    send_op(OP_TOFF, 2, 0, 1, 0, 0);
    send_op(OP_CNOT, 1, 1, 0, 0, 0);
    send_op(OP_TOFF, 0, 0, 1, 0, 0);
    send_op(OP_TOFF, 2, 1, 1, 0, 0);
    send_op(OP_CNOT, 0, 3, 0, 0, 0);
    send_op(OP_TOFF, 1, 0, 3, 0, 0);
    send_op(OP_PROB, 0, 0, 0, 3'd7, 0);
  endtask

  task automatic test_measurement();
    send_op(OP_MEAS, 0, 0, 0, 0, 32'h0);
    send_gate(1, {HALF_RT2, 32'h0}, {HALF_RT2, 32'h0}, {HALF_RT2, 32'h0},
              {-HALF_RT2, 32'h0});
    send_op(OP_MEAS, 1, 0, 0, 0, 32'hffff_ffff);
    send_op(OP_MEAS, 3, 0, 0, 0, 32'h1234_5678);
    send_op(OP_NOP, 2, 1, 0, 3'd7, 32'hffff_ffff);
    send_op(OP_PROB, 0, 0, 0, 3'd2, 0);
  endtask

  function automatic logic [31:0] to_q(input real v);
    return 32'($rtoi(v * 1073741824.0));
  endfunction

  task automatic test_random(input int n);
    qreq_t r;
    int    burst, pick, kind;
    real   th, c, s;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      r.op = pick < 5 ? OP_RESET : pick < 35 ? OP_GATE : pick < 47 ? OP_CNOT :
             pick < 57 ? OP_TOFF : pick < 67 ? OP_MEAS : pick < 82 ? OP_PROB :
             pick < 97 ? OP_BLOCH : OP_NOP;
      r.qa = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      r.qb = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      r.qc = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      r.pidx = 3'($urandom);
      r.draw = $urandom;
      kind = $urandom_range(0, 7);
      th = $urandom_range(0, 6283) / 1000.0;
      c = $cos(th);
      s = $sin(th);
      case (kind)
        0: r.g = '{{HALF_RT2, 32'h0}, {HALF_RT2, 32'h0}, {HALF_RT2, 32'h0},
                   {-HALF_RT2, 32'h0}};
        1: r.g = '{C_ZERO, C_ONE, C_ONE, C_ZERO};
        2: r.g = '{C_ZERO, {32'h0, -ONE_Q}, {32'h0, ONE_Q}, C_ZERO};
        3: r.g = '{C_ONE, C_ZERO, C_ZERO, {to_q(c), to_q(s)}};
        4: r.g = '{{to_q(c), 32'h0}, {32'h0, -to_q(s)}, {32'h0, -to_q(s)},
                   {to_q(c), 32'h0}};
        5: r.g = '{{to_q(c), 32'h0}, {-to_q(s), 32'h0}, {to_q(s), 32'h0},
                   {to_q(c), 32'h0}};
        6: r.g = '{{to_q(c), to_q(s)}, C_ZERO, C_ZERO, {to_q(c), -to_q(s)}};
        default: r.g = '{{$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom}};
      endcase
      send_req(r);
      if (burst == 0) begin
        burst = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
        idle($urandom_range(0, 15));
      end else begin
        burst--;
      end
    end
    idle(1);
  endtask

  initial begin
    #20_000_000;
    $display("** three_qubit_state_vector_sim: FAILED **");
    $finish;
  end

  initial begin
    foreach (op_count[i]) op_count[i] = 0;
    for (int i = 0; i < 8; i++) amp_model[i] = C_ZERO;
    amp_model[0] = C_ONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_probe();
    test_single_gates();
    test_entanglers();
    test_measurement();
    test_random(1250);
    wait (pending_results.size() == 0);
    repeat (600) @(posedge clk);
    $display("Covered %0d results: reset %0d, gate %0d, cnot %0d, toffoli %0d, nop %0d",
             results_seen, op_count[OP_RESET], op_count[OP_GATE], op_count[OP_CNOT],
             op_count[OP_TOFF], op_count[OP_NOP]);
    $display("measure %0d (outcome one %0d), probability %0d, bloch %0d",
             op_count[OP_MEAS], ones_measured, op_count[OP_PROB], op_count[OP_BLOCH]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** three_qubit_state_vector_sim: PASSED **");
    end else begin
      $display("** three_qubit_state_vector_sim: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
